>>> design/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared widths, sequencer states and unit interface types for the
// shortest-path block.
// ----------------------------------------------------------------------------
package bfsp_pkg;

	localparam int VID_W  = 6;   // vertex index
	localparam int VC_W   = 7;   // vertex_count register
	localparam int WGT_W  = 16;  // edge weight
	localparam int DIST_W = 32;  // distance
	localparam int EDGE_W = 2 * VID_W + WGT_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_EDGE,
		ST_EVAL,
		ST_OREAD,
		ST_OPUT,
		ST_OWAIT
	} bfsp_state_t;

	// operands handed to the relaxation unit
	typedef struct packed {
		logic signed [DIST_W-1:0] dist_from;
		logic signed [DIST_W-1:0] dist_to;
		logic signed [WGT_W-1:0]  weight;
		logic                     reached_from;
		logic                     reached_to;
	} bfsp_relax_req_t;

	// verdict of the relaxation unit
	typedef struct packed {
		logic                     relax;
		logic signed [DIST_W-1:0] sum;
	} bfsp_relax_rsp_t;

endpackage

>>> design/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsp_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/bfsp_relax.sv
// ----------------------------------------------------------------------------
// bfsp_relax
// Shared relaxation unit: saturating distance plus weight, then compare
// against the current distance of the end vertex.
// ----------------------------------------------------------------------------
module bfsp_relax
	import bfsp_pkg::*;
(
	input  bfsp_relax_req_t req,
	output bfsp_relax_rsp_t rsp
);

	logic signed [DIST_W:0]   wide_sum;
	logic signed [DIST_W-1:0] sat_sum;

	always_comb begin
		wide_sum = {req.dist_from[DIST_W-1], req.dist_from}
		         + {{(DIST_W + 1 - WGT_W){req.weight[WGT_W-1]}}, req.weight};
		// clamp to the signed distance range on overflow
		if (wide_sum[DIST_W] != wide_sum[DIST_W-1]) begin
			sat_sum = wide_sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
			                           : {1'b0, {(DIST_W-1){1'b1}}};
		end else begin
			sat_sum = wide_sum[DIST_W-1:0];
		end
		rsp.sum   = sat_sum;
		rsp.relax = req.reached_from && (!req.reached_to || (sat_sum < req.dist_to));
	end

endmodule

>>> design/bellman_ford_shortest_paths_top.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_top
// Single-source shortest paths by Bellman-Ford relaxation over a stored
// edge list, with negative-cycle check and one result per vertex.
// ----------------------------------------------------------------------------
// Edges stream in one per transfer and are written into the edge RAM at one
// transfer per cycle; edges beyond MAX_EDGES are dropped. The transfer with
// tlast set starts the run from vertex 0, and s_tready stays low until the
// last result has gone out. The run makes n-1 relaxation passes over the
// stored edges, n being the vertices in use, then one check pass; each
// edge visit is an edge RAM read, then a distance RAM read feeding the one
// shared add/compare unit. Each result then takes a distance RAM read, a
// load of the output register and a transfer; the next result waits for
// that transfer. No clearing pass is needed after reset.
// vertex_count values of 0 act as 1 and values above the supported vertex
// count are clamped; edges that name a vertex not in use are ignored.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_top
	import bfsp_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	// edge input
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
	input  logic              s_tlast,   // last_edge
	// per-vertex results
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,   // vertex[5:0], distance[37:6]
	output logic [1:0]        m_tuser,   // reached[0], negative_cycle[1]
	output logic              m_tlast,   // last_result
	// vertex_count register
	input  logic              cfg_we,
	input  logic [VC_W-1:0]   cfg_wdata
);

	// vertex indices are 6 bits wide, so no more than 64 can be addressed
	localparam int NV  = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
	localparam int VAW = $clog2(NV);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	bfsp_state_t state_q, state_d;

	logic [VC_W-1:0]   vc_q;
	logic [VC_W-1:0]   n_q;
	logic [ECW-1:0]    edge_count_q;
	logic [ECW-1:0]    k_q, k_d;
	logic [VID_W-1:0]  pass_q;
	logic [VID_W-1:0]  i_q;
	logic              neg_q;
	logic [NV-1:0]     reached_q;

	// edge under evaluation
	logic [VID_W-1:0]  a_q, b_q;
	logic [WGT_W-1:0]  w_q;
	logic              ev_q;

	// output register
	logic              out_valid_q;
	logic [VID_W-1:0]  out_vertex_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_reached_q;
	logic              out_neg_q;
	logic              out_last_q;

	logic              in_xfer, out_xfer;
	logic              edge_we;
	logic [EDGE_W-1:0] edge_rdata;
	logic [VID_W-1:0]  e_from, e_to;
	logic [WGT_W-1:0]  e_weight;

	logic              dist_we;
	logic [VAW-1:0]    dist_waddr, dist_raddr_a, dist_raddr_b;
	logic [DIST_W-1:0] dist_wdata, dist_rdata_a, dist_rdata_b;

	logic              check_pass, pass_end, relax_hit;
	logic [VC_W-1:0]   n_clamped;

	bfsp_relax_req_t   relax_req;
	bfsp_relax_rsp_t   relax_rsp;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_LOAD);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_dist_q, out_vertex_q};
	assign m_tuser  = {out_neg_q, out_reached_q};
	assign m_tlast  = out_last_q;

	// clamp the configured count into 1..NV
	always_comb begin
		if (vc_q == '0) begin
			n_clamped = VC_W'(1);
		end else if (vc_q > VC_W'(NV)) begin
			n_clamped = VC_W'(NV);
		end else begin
			n_clamped = vc_q;
		end
	end

	// ---- edge store: append while loading, read at the next edge index ----
	assign edge_we = in_xfer && (edge_count_q < ECW'(MAX_EDGES));

	bfsp_ram #(
		.WIDTH (EDGE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_count_q[EAW-1:0]),
		.wdata (s_tdata[EDGE_W-1:0]),
		.raddr (k_d[EAW-1:0]),
		.rdata (edge_rdata)
	);

	assign e_from   = edge_rdata[VID_W-1:0];
	assign e_to     = edge_rdata[2*VID_W-1:VID_W];
	assign e_weight = edge_rdata[EDGE_W-1:2*VID_W];

	// ---- distance store: two copies so both ends of an edge read at once ----
	assign dist_raddr_a = (state_q == ST_OREAD) ? i_q[VAW-1:0] : e_from[VAW-1:0];
	assign dist_raddr_b = e_to[VAW-1:0];

	bfsp_ram #(
		.WIDTH (DIST_W),
		.DEPTH (NV)
	) u_dist_ram_a (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr_a),
		.rdata (dist_rdata_a)
	);

	bfsp_ram #(
		.WIDTH (DIST_W),
		.DEPTH (NV)
	) u_dist_ram_b (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr_b),
		.rdata (dist_rdata_b)
	);

	// ---- shared relaxation unit ----
	always_comb begin
		relax_req.dist_from    = dist_rdata_a;
		relax_req.dist_to      = dist_rdata_b;
		relax_req.weight       = w_q;
		relax_req.reached_from = reached_q[a_q[VAW-1:0]];
		relax_req.reached_to   = reached_q[b_q[VAW-1:0]];
	end

	bfsp_relax u_relax (
		.req (relax_req),
		.rsp (relax_rsp)
	);

	// final pass only looks for a further improvement
	assign check_pass = ({1'b0, pass_q} == (n_q - VC_W'(1)));
	assign pass_end   = ((k_q + ECW'(1)) == edge_count_q);
	assign relax_hit  = (state_q == ST_EVAL) && ev_q && relax_rsp.relax;

	// ---- sequencer: next state, next edge index, distance writes ----
	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		dist_we    = 1'b0;
		dist_waddr = b_q[VAW-1:0];
		dist_wdata = relax_rsp.sum;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && s_tlast) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				// seed the source at distance zero, start at the first edge
				dist_we    = 1'b1;
				dist_waddr = '0;
				dist_wdata = '0;
				k_d        = '0;
				state_d    = ST_EDGE;
			end
			ST_EDGE: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				dist_we = relax_hit && !check_pass;
				k_d     = pass_end ? '0 : k_q + ECW'(1);
				state_d = (pass_end && check_pass) ? ST_OREAD : ST_EDGE;
			end
			ST_OREAD: begin
				state_d = ST_OPUT;
			end
			ST_OPUT: begin
				state_d = ST_OWAIT;
			end
			ST_OWAIT: begin
				if (out_xfer) begin
					state_d = out_last_q ? ST_LOAD : ST_OREAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q         <= VC_W'(64);
			n_q          <= VC_W'(1);
			edge_count_q <= '0;
			k_q          <= '0;
			pass_q       <= '0;
			i_q          <= '0;
			neg_q        <= 1'b0;
			reached_q    <= '0;
			ev_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			k_q <= k_d;
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			case (state_q)
				ST_LOAD: begin
					if (edge_we) begin
						edge_count_q <= edge_count_q + ECW'(1);
					end
					if (in_xfer && s_tlast) begin
						n_q <= n_clamped;
					end
				end
				ST_INIT: begin
					// only the source starts out reached
					reached_q <= NV'(1);
					pass_q    <= '0;
					neg_q     <= 1'b0;
				end
				ST_EDGE: begin
					// ignore edges that name a vertex outside the graph
					ev_q <= ({1'b0, e_from} < n_q) && ({1'b0, e_to} < n_q);
				end
				ST_EVAL: begin
					if (relax_hit && !check_pass) begin
						reached_q[b_q[VAW-1:0]] <= 1'b1;
					end
					if (relax_hit && check_pass) begin
						neg_q <= 1'b1;
					end
					if (pass_end) begin
						pass_q <= pass_q + VID_W'(1);
						i_q    <= '0;
					end
				end
				ST_OPUT: begin
					out_valid_q <= 1'b1;
				end
				ST_OWAIT: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						i_q         <= i_q + VID_W'(1);
						if (out_last_q) begin
							// next edge starts a new graph
							edge_count_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE) begin
			a_q <= e_from;
			b_q <= e_to;
			w_q <= e_weight;
		end
		if (state_q == ST_OPUT) begin
			out_vertex_q  <= i_q;
			out_reached_q <= reached_q[i_q[VAW-1:0]];
			out_dist_q    <= reached_q[i_q[VAW-1:0]] ? dist_rdata_a : '0;
			out_neg_q     <= neg_q;
			out_last_q    <= ({1'b0, i_q} + VC_W'(1)) == n_q;
		end
	end

endmodule

>>> tb/tb_bellman_ford_shortest_paths_top.sv
// ----------------------------------------------------------------------------
// tb_bellman_ford_shortest_paths_top
// Self-checking testbench for the Bellman-Ford shortest-path block.
// ----------------------------------------------------------------------------
// Streams edge lists into the block one transfer per edge. A behavioral
// Bellman-Ford solver in this file predicts the per-vertex distance,
// reachability and negative-cycle flag for every run. Each result transfer
// is compared field by field against the oldest prediction. Directed graphs
// cover the corner cases and random graphs run under several sender and
// receiver idle mixes. An edge list that overflows the edge store is also
// covered.
// ----------------------------------------------------------------------------
module tb_bellman_ford_shortest_paths_top
	import bfsp_pkg::*;
();

	localparam int     MAX_VERTICES = 64;
	localparam int     MAX_EDGES    = 256;
	localparam int     CLK_HALF     = 10;
	localparam int     SETTLE       = 8;        // cycles for the block to fall back to load
	localparam int     CYCLE_LIMIT  = 2000000;
	localparam int     PRINT_LIMIT  = 100;
	localparam longint DIST_MAX     = 64'sd2147483647;
	localparam longint DIST_MIN     = -64'sd2147483648;

	// one per-vertex result as the block should report it
	typedef struct {
		logic [VID_W-1:0]         vertex;
		logic signed [DIST_W-1:0] distance;
		logic                     reached;
		logic                     neg_cycle;
		logic                     last;
	} vertex_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;    // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
	logic              s_tlast;    // last_edge
	logic              m_tvalid;
	logic              m_tready;
	logic [39:0]       m_tdata;    // vertex[5:0], distance[37:6]
	logic [1:0]        m_tuser;    // reached[0], negative_cycle[1]
	logic              m_tlast;    // last_result
	logic              cfg_we;
	logic [VC_W-1:0]   cfg_wdata;

	// solver state, mirrors what the block holds
	logic [VID_W-1:0]         edge_src [MAX_EDGES];
	logic [VID_W-1:0]         edge_dst [MAX_EDGES];
	logic signed [WGT_W-1:0]  edge_wt  [MAX_EDGES];
	int                       edge_total;
	logic signed [DIST_W-1:0] vtx_dist    [MAX_VERTICES];
	bit                       vtx_reached [MAX_VERTICES];
	logic [VC_W-1:0]          vertex_count_reg;

	vertex_result_t pending_results [$];

	int          send_idle_pct;
	int          sink_stall_pct;
	int          error_count;
	int unsigned cycle_count;

	bellman_ford_shortest_paths_top #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// Stop a hung run; the limit is many times the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: stall at random at the falling edge, never within a rising edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic report_error(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// vertices in use: 0 acts as 1, anything above the supported count is clamped
	function automatic int active_vertices();
		int n;
		n = vertex_count_reg;
		if (n < 1) n = 1;
		if (n > MAX_VERTICES) n = MAX_VERTICES;
		return n;
	endfunction

	// True when stored edge k gives its end vertex a shorter (or first) distance.
	// Ignore edges that leave the active vertex range or start at an unreached vertex.
	function automatic bit edge_lowers_distance(input int k, input int n,
			output logic signed [DIST_W-1:0] sum, output int dst);
		int     src;
		longint wide;
		src = edge_src[k];
		dst = edge_dst[k];
		sum = '0;
		if (src >= n || dst >= n || !vtx_reached[src]) return 1'b0;
		wide = longint'(vtx_dist[src]) + longint'(edge_wt[k]);
		if (wide > DIST_MAX) wide = DIST_MAX;
		if (wide < DIST_MIN) wide = DIST_MIN;
		sum = DIST_W'(wide);
		return !vtx_reached[dst] || sum < vtx_dist[dst];
	endfunction

	// Store one accepted edge; on the last edge solve the graph and queue one
	// expected result per active vertex.
	function automatic void absorb_edge(input logic [VID_W-1:0] src,
			input logic [VID_W-1:0] dst, input logic signed [WGT_W-1:0] wt,
			input logic last);
		int                       n;
		int                       to;
		bit                       neg;
		logic signed [DIST_W-1:0] sum;
		vertex_result_t           r;
		// drop edges once the store is full
		if (edge_total < MAX_EDGES) begin
			edge_src[edge_total] = src;
			edge_dst[edge_total] = dst;
			edge_wt[edge_total]  = wt;
			edge_total++;
		end
		if (!last) return;
		n = active_vertices();
		for (int v = 0; v < n; v++) vtx_reached[v] = 1'b0;
		vtx_dist[0]    = '0;
		vtx_reached[0] = 1'b1;
		neg            = 1'b0;
		// n-1 relaxation passes, then one check pass for a reachable negative cycle
		for (int p = 0; p + 1 < n; p++) begin
			for (int k = 0; k < edge_total; k++) begin
				if (edge_lowers_distance(k, n, sum, to)) begin
					vtx_dist[to]    = sum;
					vtx_reached[to] = 1'b1;
				end
			end
		end
		for (int k = 0; k < edge_total; k++) begin
			if (edge_lowers_distance(k, n, sum, to)) neg = 1'b1;
		end
		for (int v = 0; v < n; v++) begin
			r.vertex    = VID_W'(v);
			r.distance  = vtx_reached[v] ? vtx_dist[v] : '0;   // unreached reports zero
			r.reached   = vtx_reached[v];
			r.neg_cycle = neg;
			r.last      = (v + 1 == n);
			pending_results.push_back(r);
		end
		// the next edge starts a new graph
		edge_total = 0;
	endfunction

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin : check_results
		vertex_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result for vertex %0d with none expected",
					m_tdata[VID_W-1:0]));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[VID_W-1:0] !== want.vertex)
					report_error($sformatf("vertex %0d, expected %0d",
						m_tdata[VID_W-1:0], want.vertex));
				if (m_tdata[VID_W +: DIST_W] !== want.distance)
					report_error($sformatf("vertex %0d distance %0d, expected %0d", want.vertex,
						$signed(m_tdata[VID_W +: DIST_W]), want.distance));
				if (m_tuser[0] !== want.reached)
					report_error($sformatf("vertex %0d reached %b, expected %b",
						want.vertex, m_tuser[0], want.reached));
				if (m_tuser[1] !== want.neg_cycle)
					report_error($sformatf("vertex %0d negative_cycle %b, expected %b",
						want.vertex, m_tuser[1], want.neg_cycle));
				if (m_tlast !== want.last)
					report_error($sformatf("vertex %0d last %b, expected %b",
						want.vertex, m_tlast, want.last));
			end
		end
	end

	// Send one edge. Entered and left at a falling edge; the valid stays high
	// after the transfer so a following edge goes out back to back.
	task automatic send_edge(input int src, input int dst, input int wt, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {4'b0, WGT_W'(wt), VID_W'(dst), VID_W'(src)};
		s_tlast  = last;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_edge(VID_W'(src), VID_W'(dst), WGT_W'(wt), last);
		@(negedge clk);
	endtask

	// Hold the sender until every predicted result is in, then let the block settle.
	task automatic drain_results();
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write vertex_count; only ever done with the block idle.
	task automatic write_vertex_count(input int value);
		drain_results();
		cfg_wdata = VC_W'(value);
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we           = 1'b0;
		vertex_count_reg = VC_W'(value);
	endtask

	// Random edge list, mostly inside the active range, with a few stray edges.
	task automatic send_random_graph(input int n_edges);
		int n;
		int src;
		int dst;
		int wt;
		n = active_vertices();
		for (int j = 0; j < n_edges; j++) begin
			if ($urandom_range(99) < 12) begin
				src = $urandom_range(63);
				dst = $urandom_range(63);
			end else begin
				// bias starts toward low vertices so paths grow out of the source
				src = $urandom_range(1) ? $urandom_range(n - 1)
					: $urandom_range((j < n - 1) ? j : n - 1);
				dst = $urandom_range(n - 1);
			end
			case ($urandom_range(19))
				0:       wt = -32768;
				1:       wt = 32767;
				2, 3, 4: wt = int'($urandom_range(65535)) - 32768;
				default: wt = int'($urandom_range(90)) - 20;
			endcase
			send_edge(src, dst, wt, j == n_edges - 1);
		end
	endtask

	// Run on the reset value of vertex_count (64) before any register write.
	task automatic test_reset_count();
		send_edge(0, 63, 32767, 1'b0);
		send_edge(63, 1, -32768, 1'b0);
		send_edge(1, 2, 7, 1'b1);
	endtask

	// Extreme weights, a second, longer path to a vertex, edges outside the range.
	task automatic test_weighted_paths();
		write_vertex_count(6);
		send_edge(0, 1, 32767, 1'b0);
		send_edge(1, 2, -32768, 1'b0);
		send_edge(0, 3, 5, 1'b0);
		send_edge(3, 2, 1, 1'b0);
		send_edge(4, 63, 1, 1'b0);      // end vertex out of range: ignore
		send_edge(63, 0, -5, 1'b0);     // start vertex out of range: ignore
		send_edge(2, 4, 0, 1'b1);       // vertex 5 stays unreached
	endtask

	// Reachable negative cycle, then one that hangs off an unreached vertex.
	task automatic test_negative_cycle();
		write_vertex_count(4);
		send_edge(0, 1, 3, 1'b0);
		send_edge(1, 2, -2, 1'b0);
		send_edge(2, 1, -2, 1'b1);
		send_edge(2, 3, -5, 1'b0);
		send_edge(3, 2, -5, 1'b0);
		send_edge(0, 1, 1, 1'b1);
	endtask

	// vertex_count of 0, 1 and 127 (clamped to the full 64).
	task automatic test_vertex_count_limits();
		write_vertex_count(0);
		send_edge(0, 0, -1, 1'b1);      // negative self loop at the source
		write_vertex_count(1);
		send_edge(5, 7, 100, 1'b1);
		write_vertex_count(127);
		send_edge(0, 63, 100, 1'b0);
		send_edge(63, 62, -32768, 1'b0);
		send_edge(62, 0, 32767, 1'b1);
	endtask

	// Overfill the edge store; the dropped last edge must still start the run.
	task automatic test_store_overflow();
		write_vertex_count(4);
		send_idle_pct  = 27;
		sink_stall_pct = 27;
		for (int j = 0; j < MAX_EDGES + 3; j++)
			send_edge($urandom_range(3), $urandom_range(3),
				int'($urandom_range(55)) - 5, 1'b0);
		send_edge(0, 3, -32768, 1'b1);
	endtask

	// Random graphs under each idle mix, with vertex_count changed between runs.
	task automatic test_random_graphs();
		int send_mix [4] = '{0, 56, 0, 27};
		int sink_mix [4] = '{0, 0, 56, 27};
		int sent;
		int n_edges;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_mix[ph];
			sink_stall_pct = sink_mix[ph];
			sent           = 0;
			while (sent < 28) begin
				if ($urandom_range(3) == 0) begin
					case ($urandom_range(19))
						0:       write_vertex_count(0);
						1:       write_vertex_count(1);
						2:       write_vertex_count(64);
						3:       write_vertex_count(127);
						4, 5, 6: write_vertex_count($urandom_range(9, 63));
						default: write_vertex_count($urandom_range(2, 8));
					endcase
				end else if ($urandom_range(4) == 0) begin
					drain_results();
				end
				n_edges = ($urandom_range(9) == 0) ? $urandom_range(1, 40)
					: $urandom_range(1, 12);
				send_random_graph(n_edges);
				sent += n_edges;
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		s_tlast          = 1'b0;
		m_tready         = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		send_idle_pct    = 0;
		sink_stall_pct   = 0;
		error_count      = 0;
		cycle_count      = 0;
		edge_total       = 0;
		vertex_count_reg = VC_W'(64);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_count();
		test_weighted_paths();
		test_negative_cycle();
		test_vertex_count_limits();
		test_random_graphs();
		test_store_overflow();

		drain_results();
		repeat (4 * SETTLE) @(posedge clk);
		if (pending_results.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
